// ===== sv/cdsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_pkg
// Shared types and constants for the CAN signal extract and scale block.
// ----------------------------------------------------------------------------
package cdsd_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
    localparam int FRACTION_BITS = 16;

    localparam int FACTOR_W  = 32;
    localparam int OFFSET_W  = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W    = 65;
    localparam int SUM_W     = 98;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_BIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_SIGNED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET = 3'd5;

    localparam logic ORDER_INTEL    = 1'b0;
    localparam logic ORDER_MOTOROLA = 1'b1;

    localparam logic signed [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1 << FRACTION_BITS);

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PHYS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [5:0]                  start_bit;
        logic [6:0]                  bit_length;
        logic                        byte_order;
        logic                        value_signed;
        logic signed [FACTOR_W-1:0]  scale_factor;
        logic signed [OFFSET_W-1:0]  scale_offset;
    } cfg_t;

endpackage

// ===== sv/cdsd_extract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_extract
// Pulls the configured signal out of a payload in Intel or Motorola order,
// sign-extends signed ones; flags bits outside the payload, lengths 0 or >64.
// ----------------------------------------------------------------------------
module cdsd_extract
(
    input  cdsd_pkg::cfg_t cfg,
    input  logic [63:0]    payload,
    output logic [63:0]    raw_value,
    output logic           range_error
);
    import cdsd_pkg::*;

    logic [63:0] payload_m;
    logic [63:0] reversed;
    logic [63:0] moto_word;
    logic [63:0] aligned;
    logic [63:0] len_mask;
    logic [63:0] bits;
    logic [2:0]  sbyte;
    logic [2:0]  soff;
    logic [5:0]  moto_shift;
    logic [6:0]  len_eff;
    logic [6:0]  len_m1;
    logic [7:0]  intel_end;
    logic [7:0]  moto_avail;
    logic        len_bad;
    logic        out_of_range;

    assign sbyte = cfg.start_bit[5:3];
    assign soff  = cfg.start_bit[2:0];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            payload_m[8*i +: 8] = (i < PAYLOAD_BYTES) ? payload[8*i +: 8] : 8'h00;
        end
        // byte j of reversed is payload byte 7-j
        for (int j = 0; j < 8; j++)
        begin
            reversed[8*j +: 8] = payload_m[8*(7-j) +: 8];
        end
    end

    always_comb
    begin
        len_bad = (cfg.bit_length == 7'd0) || (cfg.bit_length > 7'd64);
        if (cfg.bit_length == 7'd0)
        begin
            len_eff = 7'd1;
        end
        else if (cfg.bit_length > 7'd64)
        begin
            len_eff = 7'd64;
        end
        else
        begin
            len_eff = cfg.bit_length;
        end
    end

    // Motorola: bring the start byte to byte 0 with lower bytes following upward
    assign moto_shift = {3'd7 - sbyte, 3'b000};
    assign moto_word  = reversed >> moto_shift;
    assign aligned    = (cfg.byte_order == ORDER_MOTOROLA) ? (moto_word >> soff)
                                                           : (payload_m >> cfg.start_bit);
    assign len_mask   = ~(ALL_ONES << len_eff);
    assign bits       = aligned & len_mask;
    assign len_m1     = len_eff - 7'd1;

    always_comb
    begin
        if (cfg.value_signed && (len_eff != 7'd64) && bits[len_m1[5:0]])
        begin
            raw_value = bits | ~len_mask;
        end
        else
        begin
            raw_value = bits;
        end
    end

    assign intel_end  = {2'b00, cfg.start_bit} + {1'b0, len_eff};
    assign moto_avail = {2'b00, sbyte, 3'b000} + 8'd8 - {5'd0, soff};

    always_comb
    begin
        if (cfg.byte_order == ORDER_MOTOROLA)
        begin
            out_of_range = ({1'b0, sbyte} >= 4'(PAYLOAD_BYTES))
                        || ({1'b0, len_eff} > moto_avail);
        end
        else
        begin
            out_of_range = intel_end > 8'(PAYLOAD_BITS);
        end
    end

    assign range_error = len_bad || out_of_range;

endmodule

// ===== sv/cdsd_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_scale
// Scales the raw value: two registered 33x32 partial products, then the
// exact sum with the offset and saturation to 64 bits.
// ----------------------------------------------------------------------------
module cdsd_scale
(
    input  logic                                   clk,
    input  logic                                   advance,
    input  logic [63:0]                            raw_value,
    input  logic                                   value_signed,
    input  logic signed [cdsd_pkg::FACTOR_W-1:0]   scale_factor,
    input  logic signed [cdsd_pkg::OFFSET_W-1:0]   scale_offset,
    output logic [63:0]                            physical_value,
    output logic                                   saturated
);
    import cdsd_pkg::*;

    logic signed [32:0]       lo_op;
    logic signed [32:0]       hi_op;
    logic signed [PROD_W-1:0] plo_next;
    logic signed [PROD_W-1:0] phi_next;
    logic signed [PROD_W-1:0] plo_reg;
    logic signed [PROD_W-1:0] phi_reg;
    logic signed [SUM_W-1:0]  hi_ext;
    logic signed [SUM_W-1:0]  lo_ext;
    logic signed [SUM_W-1:0]  off_ext;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-64:0]        sum_top;

    // raw is a 65-bit signed value: zero-extended unless the signal is signed
    assign lo_op    = $signed({1'b0, raw_value[31:0]});
    assign hi_op    = $signed({value_signed & raw_value[63], raw_value[63:32]});
    assign plo_next = lo_op * scale_factor;
    assign phi_next = hi_op * scale_factor;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    assign hi_ext  = {phi_reg[PROD_W-1], phi_reg, 32'd0};
    assign lo_ext  = {{(SUM_W-PROD_W){plo_reg[PROD_W-1]}}, plo_reg};
    assign off_ext = {{(SUM_W-OFFSET_W){scale_offset[OFFSET_W-1]}}, scale_offset};
    assign sum     = hi_ext + lo_ext + off_ext;
    assign sum_top = sum[SUM_W-1:63];

    always_comb
    begin
        saturated = !((&sum_top) || (~|sum_top));
        if (saturated)
        begin
            physical_value = sum[SUM_W-1] ? PHYS_MIN : PHYS_MAX;
        end
        else
        begin
            physical_value = sum[63:0];
        end
    end

endmodule

// ===== sv/can_dbc_signal_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_dbc_signal_decode
// Each beat passes the input, extract, product and result registers in turn.
// Throughput: one beat per cycle; the whole pipeline holds only while a result
// beat is stalled. Reset clears all valid flags and loads the default
// configuration (8-bit Intel unsigned signal at bit 0, factor 1.0).
// ----------------------------------------------------------------------------
module can_dbc_signal_decode
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [cdsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cdsd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [63:0]                           payload,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [63:0]                           raw_value,
    output logic signed [63:0]                    physical_value,
    output logic                                  saturated,
    output logic                                  range_error
);
    import cdsd_pkg::*;

    cfg_t        cfg_reg;
    logic        advance;
    logic        v0_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        out_valid_reg;
    logic [63:0] payload_reg;
    logic [63:0] raw_next;
    logic        err_next;
    logic [63:0] raw1_reg;
    logic        err1_reg;
    logic [63:0] raw2_reg;
    logic        err2_reg;
    logic [63:0] phys_next;
    logic        sat_next;
    logic [63:0] raw_out_reg;
    logic [63:0] phys_out_reg;
    logic        sat_out_reg;
    logic        err_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_bit    <= '0;
            cfg_reg.bit_length   <= 7'd8;
            cfg_reg.byte_order   <= ORDER_INTEL;
            cfg_reg.value_signed <= 1'b0;
            cfg_reg.scale_factor <= FACTOR_ONE;
            cfg_reg.scale_offset <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_BIT:    cfg_reg.start_bit    <= cfg_data[5:0];
                REG_BIT_LENGTH:   cfg_reg.bit_length   <= cfg_data[6:0];
                REG_BYTE_ORDER:   cfg_reg.byte_order   <= cfg_data[0];
                REG_VALUE_SIGNED: cfg_reg.value_signed <= cfg_data[0];
                REG_SCALE_FACTOR: cfg_reg.scale_factor <= $signed(cfg_data[FACTOR_W-1:0]);
                REG_SCALE_OFFSET: cfg_reg.scale_offset <= $signed(cfg_data[OFFSET_W-1:0]);
                default:          ;
            endcase
        end
    end

    // hold every stage while a finished beat waits at the output
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    cdsd_extract u_extract
    (
        .cfg         (cfg_reg),
        .payload     (payload_reg),
        .raw_value   (raw_next),
        .range_error (err_next)
    );

    cdsd_scale u_scale
    (
        .clk            (clk),
        .advance        (advance),
        .raw_value      (raw1_reg),
        .value_signed   (cfg_reg.value_signed),
        .scale_factor   (cfg_reg.scale_factor),
        .scale_offset   (cfg_reg.scale_offset),
        .physical_value (phys_next),
        .saturated      (sat_next)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            payload_reg  <= payload;
            raw1_reg     <= raw_next;
            err1_reg     <= err_next;
            raw2_reg     <= raw1_reg;
            err2_reg     <= err1_reg;
            raw_out_reg  <= raw2_reg;
            err_out_reg  <= err2_reg;
            phys_out_reg <= phys_next;
            sat_out_reg  <= sat_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign raw_value      = raw_out_reg;
    assign physical_value = $signed(phys_out_reg);
    assign saturated      = sat_out_reg;
    assign range_error    = err_out_reg;

endmodule

// ===== tb/can_dbc_signal_decode_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_dbc_signal_decode_tb
// Self-checking bench for the CAN signal extract and scale block. A scoreboard
// class mirrors the configuration registers, predicts raw and scaled values for
// every accepted payload beat and checks each result beat in order. Directed
// layouts cover the field extremes and error cases; random layouts and payloads
// follow under varying source gaps and sink stalls.
// ----------------------------------------------------------------------------
module can_dbc_signal_decode_tb;

    import cdsd_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int PHASE_ITEMS  = 25;
    localparam int RANDOM_PHASES = 46;

    typedef struct {
        logic [63:0]        raw;
        logic signed [63:0] phys;
        logic               sat;
        logic               range_err;
    } decoded_t;

    class decode_scoreboard;
        cfg_t     layout;
        decoded_t expected_decodes[$];
        int       failures;

        function new();
            layout.start_bit    = 6'd0;
            layout.bit_length   = 7'd8;
            layout.byte_order   = ORDER_INTEL;
            layout.value_signed = 1'b0;
            layout.scale_factor = FACTOR_ONE;
            layout.scale_offset = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_START_BIT:    layout.start_bit    = data[5:0];
                REG_BIT_LENGTH:   layout.bit_length   = data[6:0];
                REG_BYTE_ORDER:   layout.byte_order   = data[0];
                REG_VALUE_SIGNED: layout.value_signed = data[0];
                REG_SCALE_FACTOR: layout.scale_factor = data[FACTOR_W-1:0];
                REG_SCALE_OFFSET: layout.scale_offset = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function decoded_t decode_signal(logic [63:0] p);
            decoded_t d;
            int len, sb, sbyte, soff, k, r, byte_i, bit_i;
            logic [63:0] raw;
            logic signed [129:0] rx, fx, ox, sum;
            d.range_err = 1'b0;
            raw = '0;
            len = int'(layout.bit_length);
            sb = int'(layout.start_bit);
            sbyte = sb / 8;
            soff = sb % 8;
            // out-of-range lengths are clamped but still flagged
            if (len < 1)
            begin
                len = 1;
                d.range_err = 1'b1;
            end
            if (len > 64)
            begin
                len = 64;
                d.range_err = 1'b1;
            end
            for (k = 0; k < len; k++)
            begin
                if (layout.byte_order == ORDER_INTEL)
                begin
                    byte_i = (sb + k) / 8;
                    bit_i = (sb + k) % 8;
                end
                else if (k < 8 - soff)
                begin
                    byte_i = sbyte;
                    bit_i = soff + k;
                end
                else
                begin
                    r = k - (8 - soff);
                    byte_i = sbyte - 1 - r / 8;
                    bit_i = r % 8;
                end
                if (byte_i < 0 || byte_i >= PAYLOAD_BYTES)
                    d.range_err = 1'b1;
                else
                    raw[k] = p[byte_i * 8 + bit_i];
            end
            if (layout.value_signed && len < 64 && raw[len-1])
                raw = raw | (ALL_ONES << len);
            // exact product and sum in a range wide enough for any operands
            rx = {{66{layout.value_signed & raw[63]}}, raw};
            fx = {{98{layout.scale_factor[FACTOR_W-1]}}, layout.scale_factor};
            ox = {{82{layout.scale_offset[OFFSET_W-1]}}, layout.scale_offset};
            sum = rx * fx + ox;
            d.raw = raw;
            if (sum[129:63] != {67{sum[63]}})
            begin
                d.sat = 1'b1;
                d.phys = sum[129] ? PHYS_MIN : PHYS_MAX;
            end
            else
            begin
                d.sat = 1'b0;
                d.phys = sum[63:0];
            end
            return d;
        endfunction

        function void note_payload(logic [63:0] p);
            expected_decodes.push_back(decode_signal(p));
        endfunction

        function void check_result(logic [63:0] raw, logic signed [63:0] phys,
                                   logic sat, logic range_err);
            decoded_t e;
            if (expected_decodes.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: raw %h phys %h sat %b err %b",
                             raw, phys, sat, range_err);
                return;
            end
            e = expected_decodes.pop_front();
            if (e.raw !== raw || e.phys !== phys || e.sat !== sat
                || e.range_err !== range_err)
            begin
                failures++;
                if (failures <= 10)
                    $display("decode mismatch: raw %h/%h phys %h/%h sat %b/%b err %b/%b",
                             e.raw, raw, e.phys, phys, e.sat, sat, e.range_err, range_err);
            end
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [63:0]           payload = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [63:0]           raw_value;
    logic signed [63:0]    physical_value;
    logic                  saturated;
    logic                  range_error;

    int gap_pct = 0;
    int stall_pct = 0;

    decode_scoreboard board = new();

    can_dbc_signal_decode DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .raw_value      (raw_value),
        .physical_value (physical_value),
        .saturated      (saturated),
        .range_error    (range_error)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL can_dbc_signal_decode");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(raw_value, physical_value, saturated, range_error);
    end

    task automatic push_payload(input logic [63:0] p);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        payload <= p;
        @(posedge clk);
        // hold the beat while stalled
        while (in_stall)
            @(posedge clk);
        board.note_payload(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // drain the pipe, then load all six registers; unused data bits are random
    task automatic apply_layout(input cfg_t c);
        logic [47:0] junk;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        junk = 48'({$urandom(), $urandom()});
        write_reg(REG_START_BIT, {junk[47:6], c.start_bit});
        write_reg(REG_BIT_LENGTH, {junk[47:7], c.bit_length});
        write_reg(REG_BYTE_ORDER, {junk[47:1], c.byte_order});
        write_reg(REG_VALUE_SIGNED, {junk[47:1], c.value_signed});
        write_reg(REG_SCALE_FACTOR, {junk[47:32], c.scale_factor});
        write_reg(REG_SCALE_OFFSET, c.scale_offset);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic cfg_t make_layout(int sb, int len, logic order, logic sgn,
                                         logic [31:0] factor, logic [47:0] offset);
        cfg_t c;
        c.start_bit = sb[5:0];
        c.bit_length = len[6:0];
        c.byte_order = order;
        c.value_signed = sgn;
        c.scale_factor = factor;
        c.scale_offset = offset;
        return c;
    endfunction

    function automatic cfg_t random_layout();
        cfg_t c;
        int sb, max_len, len, pick;
        logic [63:0] wide;
        c.byte_order = 1'($urandom_range(1));
        c.value_signed = 1'($urandom_range(1));
        sb = $urandom_range(63);
        c.start_bit = sb[5:0];
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            // signal fits the payload
            max_len = (c.byte_order == ORDER_INTEL) ? 64 - sb : 8 - sb % 8 + 8 * (sb / 8);
            len = ($urandom_range(3) == 0) ? max_len : $urandom_range(max_len, 1);
        end
        else if (pick < 90)
        begin
            len = $urandom_range(64, 1);
        end
        else
        begin
            len = $urandom_range(1) ? 0 : $urandom_range(127, 65);
        end
        c.bit_length = len[6:0];
        wide = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0: c.scale_factor = FACTOR_ONE;
            1: c.scale_factor = $urandom_range(1) ? 32'($urandom_range(1 << 20))
                                                 : -32'($urandom_range(1 << 20));
            2: c.scale_factor = wide[31:0];
            3: c.scale_factor = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: c.scale_factor = -FACTOR_ONE;
            default: c.scale_factor = '0;
        endcase
        case ($urandom_range(3))
            0: c.scale_offset = '0;
            1: c.scale_offset = $urandom_range(1) ? 48'($urandom_range(1 << 24))
                                                 : -48'($urandom_range(1 << 24));
            2: c.scale_offset = wide[63:16];
            default: c.scale_offset = $urandom_range(1) ? 48'h8000_0000_0000
                                                       : 48'h7FFF_FFFF_FFFF;
        endcase
        return c;
    endfunction

    function automatic logic [63:0] random_payload();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(63);
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            2: return one_hot;
            3: return ~one_hot;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial
    begin
        cfg_t dir_layouts[9];
        int ph, n;
        dir_layouts[0] = make_layout(0, 64, ORDER_INTEL, 1'b0, FACTOR_ONE, '0);
        dir_layouts[1] = make_layout(0, 64, ORDER_INTEL, 1'b1, 32'h7FFF_FFFF,
                                     48'h8000_0000_0000);
        dir_layouts[2] = make_layout(63, 1, ORDER_INTEL, 1'b1, 32'h8000_0000,
                                     48'h7FFF_FFFF_FFFF);
        dir_layouts[3] = make_layout(60, 16, ORDER_INTEL, 1'b0, FACTOR_ONE, 48'd5);
        dir_layouts[4] = make_layout(56, 64, ORDER_MOTOROLA, 1'b1, -FACTOR_ONE, '0);
        dir_layouts[5] = make_layout(3, 12, ORDER_MOTOROLA, 1'b1, 32'd3, 48'hFFFF_FFFF_0000);
        dir_layouts[6] = make_layout(10, 0, ORDER_INTEL, 1'b1, FACTOR_ONE, '0);
        dir_layouts[7] = make_layout(5, 127, ORDER_MOTOROLA, 1'b0, 32'd1, 48'd1);
        dir_layouts[8] = make_layout(0, 65, ORDER_INTEL, 1'b0, '0, 48'h1234_5678_9ABC);

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout first, without any register write
        push_payload('0);
        push_payload(ALL_ONES);
        push_payload(64'h0123_4567_89AB_CDEF);
        in_valid <= 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            apply_layout(dir_layouts[i]);
            push_payload(ALL_ONES);
            push_payload(64'h8123_4567_89AB_CDEF);
            in_valid <= 1'b0;
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_layout(random_layout());
            case (ph % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 48;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 48;
                end
                default:
                begin
                    gap_pct = 20;
                    stall_pct = 20;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                push_payload(random_payload());
            in_valid <= 1'b0;
        end

        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY * 2) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("PASS can_dbc_signal_decode");
        else
            $display("FAIL can_dbc_signal_decode");
        $finish;
    end

endmodule

// ===== can_dbc_signal_decode.f =====
sv/cdsd_pkg.sv
sv/cdsd_extract.sv
sv/cdsd_scale.sv
sv/can_dbc_signal_decode.sv
tb/can_dbc_signal_decode_tb.sv
